@@ rtl/arr_pkg.sv @@
// Package for the ARP reply responder: reply job type, frame constants,
// register indexes and the reply byte function. No dependencies.
`default_nettype none

package arr_pkg;

   localparam int unsigned FRAME_LEN = 42;
   localparam int unsigned POS_W     = 6;
   localparam int unsigned MAC_W     = 48;
   localparam int unsigned IP_W      = 32;
   localparam int unsigned CSR_W     = 48;

   localparam logic [POS_W-1:0] POS_TYPE_HI  = 6'd12;
   localparam logic [POS_W-1:0] POS_TYPE_LO  = 6'd13;
   localparam logic [POS_W-1:0] POS_SHA      = 6'd22;
   localparam logic [POS_W-1:0] POS_SPA      = 6'd28;
   localparam logic [POS_W-1:0] POS_SPA_END  = 6'd32;
   localparam logic [POS_W-1:0] POS_TPA      = 6'd38;
   localparam logic [POS_W-1:0] POS_FULL     = 6'd42;
   localparam logic [POS_W-1:0] POS_LAST     = 6'd41;

   localparam logic [7:0]  ETH_TYPE_ARP_HI = 8'h08;
   localparam logic [7:0]  ETH_TYPE_ARP_LO = 8'h06;
   localparam logic [15:0] ETH_TYPE_ARP    = 16'h0806;
   localparam logic [15:0] ARP_HTYPE_ETH   = 16'h0001;
   localparam logic [15:0] ARP_PTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  ARP_HW_LEN      = 8'h06;
   localparam logic [7:0]  ARP_PROTO_LEN   = 8'h04;
   localparam logic [15:0] ARP_OP_REPLY    = 16'h0002;

   localparam logic [IP_W-1:0]  LOCAL_IP_RESET  = 32'h0A42_1844;
   localparam logic [MAC_W-1:0] LOCAL_MAC_RESET = 48'h0;

   typedef enum logic [0:0] {
      CSR_LOCAL_IP  = 1'b0,
      CSR_LOCAL_MAC = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [MAC_W-1:0] peer_mac;
      logic [IP_W-1:0]  peer_ip;
   } job_type;

   function automatic logic [7:0] reply_byte(
      input logic [POS_W-1:0] k,
      input logic [MAC_W-1:0] peer_mac,
      input logic [IP_W-1:0]  peer_ip,
      input logic [MAC_W-1:0] local_mac,
      input logic [IP_W-1:0]  local_ip
   );
      logic [FRAME_LEN*8-1:0] frame;
      logic [POS_W-1:0]       rev;
      logic [POS_W+2:0]       bit_ofs;
      frame = {peer_mac, local_mac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ARP_PTYPE_IPV4,
               ARP_HW_LEN, ARP_PROTO_LEN, ARP_OP_REPLY, local_mac, local_ip,
               peer_mac, peer_ip};
      rev     = POS_LAST - k;
      bit_ofs = {rev, 3'b000};
      return frame[bit_ofs +: 8];
   endfunction

endpackage

`default_nettype wire

@@ rtl/arr_rx_parser.sv @@
// Receive-side parser: counts frame bytes, checks the ethertype, captures
// the ARP sender and target addresses and raises a reply job. Uses arr_pkg.
`default_nettype none

module arr_rx_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               rx_byte,
   input  wire logic                     rx_last,
   input  wire logic [arr_pkg::IP_W-1:0] local_ip,
   output arr_pkg::job_type              job
);

   logic [arr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      arp_ff, arp_in;
   logic [arr_pkg::MAC_W-1:0] mac_ff, mac_in;
   logic [arr_pkg::IP_W-1:0]  spa_ff, spa_in;
   logic [arr_pkg::IP_W-1:0]  tpa_ff, tpa_in;
   logic                      arp_next;
   logic                      hit;

   always_comb begin
      arp_next = arp_ff;
      mac_in   = mac_ff;
      spa_in   = spa_ff;
      tpa_in   = tpa_ff;
      if (pos_ff == arr_pkg::POS_TYPE_HI) begin
         arp_next = (rx_byte == arr_pkg::ETH_TYPE_ARP_HI);
      end else if (pos_ff == arr_pkg::POS_TYPE_LO) begin
         arp_next = arp_ff && (rx_byte == arr_pkg::ETH_TYPE_ARP_LO);
      end else if (pos_ff >= arr_pkg::POS_SHA && pos_ff < arr_pkg::POS_SPA) begin
         mac_in = {mac_ff[arr_pkg::MAC_W-9:0], rx_byte};
      end else if (pos_ff >= arr_pkg::POS_SPA && pos_ff < arr_pkg::POS_SPA_END) begin
         spa_in = {spa_ff[arr_pkg::IP_W-9:0], rx_byte};
      end else if (pos_ff >= arr_pkg::POS_TPA && pos_ff < arr_pkg::POS_FULL) begin
         tpa_in = {tpa_ff[arr_pkg::IP_W-9:0], rx_byte};
      end

      hit = rx_last && (pos_ff >= arr_pkg::POS_LAST) && arp_next && (tpa_in == local_ip);

      if (rx_last) begin
         pos_in = '0;
         arp_in = 1'b0;
      end else begin
         pos_in = (pos_ff < arr_pkg::POS_FULL) ? pos_ff + 6'd1 : pos_ff;
         arp_in = arp_next;
      end

      job.valid    = accept && hit;
      job.peer_mac = mac_in;
      job.peer_ip  = spa_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         arp_ff <= 1'b0;
         mac_ff <= '0;
         spa_ff <= '0;
         tpa_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         arp_ff <= arp_in;
         mac_ff <= mac_in;
         spa_ff <= spa_in;
         tpa_ff <= tpa_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/arr_tx_builder.sv @@
// Reply builder: one pending job slot, the active reply's addresses and a
// byte counter feeding the registered result stage. Uses arr_pkg.
`default_nettype none

module arr_tx_builder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire arr_pkg::job_type          job,
   output logic                           job_ready,
   input  wire logic [arr_pkg::MAC_W-1:0] local_mac,
   input  wire logic [arr_pkg::IP_W-1:0]  local_ip,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_tx_byte,
   output logic                           rsp_tx_last
);

   logic                      pend_ff, pend_in;
   logic [arr_pkg::MAC_W-1:0] pend_mac_ff, pend_mac_in;
   logic [arr_pkg::IP_W-1:0]  pend_ip_ff, pend_ip_in;
   logic                      active_ff, active_in;
   logic [arr_pkg::POS_W-1:0] idx_ff, idx_in;
   logic [arr_pkg::MAC_W-1:0] cur_mac_ff, cur_mac_in;
   logic [arr_pkg::IP_W-1:0]  cur_ip_ff, cur_ip_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                byte_ff, byte_in;
   logic                      last_ff, last_in;
   logic                      advance;

   assign job_ready   = !pend_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_tx_last = last_ff;
   assign advance     = !valid_ff || rsp_ready;

   always_comb begin
      pend_in     = pend_ff;
      pend_mac_in = pend_mac_ff;
      pend_ip_in  = pend_ip_ff;
      active_in   = active_ff;
      idx_in      = idx_ff;
      cur_mac_in  = cur_mac_ff;
      cur_ip_in   = cur_ip_ff;
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;

      if (advance) begin
         valid_in = active_ff;
         if (active_ff) begin
            byte_in = arr_pkg::reply_byte(idx_ff, cur_mac_ff, cur_ip_ff, local_mac, local_ip);
            last_in = (idx_ff == arr_pkg::POS_LAST);
            if (idx_ff == arr_pkg::POS_LAST) begin
               active_in = 1'b0;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
      end

      if (!active_ff && pend_ff) begin
         active_in  = 1'b1;
         idx_in     = '0;
         cur_mac_in = pend_mac_ff;
         cur_ip_in  = pend_ip_ff;
         pend_in    = 1'b0;
      end

      if (job.valid) begin
         pend_in     = 1'b1;
         pend_mac_in = job.peer_mac;
         pend_ip_in  = job.peer_ip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         active_ff <= 1'b0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_mac_ff <= pend_mac_in;
      pend_ip_ff  <= pend_ip_in;
      cur_mac_ff  <= cur_mac_in;
      cur_ip_ff   <= cur_ip_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
   end

endmodule

`default_nettype wire

@@ rtl/arp_reply_responder.sv @@
// ARP reply responder top level: CSRs, receive parser and reply builder.
// Depends on arr_pkg, arr_rx_parser and arr_tx_builder.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_rx_byte, req_rx_last
//   rsp       out        rsp_valid / rsp_ready   rsp_tx_byte, rsp_tx_last
//   csr       in         csr_wr_en               csr_index, csr_wdata
//
// One received byte per cycle; the parser never stalls on its own.
// A matching ARP request yields 42 reply bytes, one per cycle while rsp_ready
// is high, from a byte counter; a new reply follows the previous last byte.
// One finished request can wait in a pending slot; req_ready drops only while
// that slot is full. Reset is synchronous; the CSRs return to their defaults.
`default_nettype none

module arp_reply_responder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_rx_byte,
   input  wire logic                      req_rx_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_tx_byte,
   output logic                           rsp_tx_last,
   input  wire logic                      csr_wr_en,
   input  wire logic [0:0]                csr_index,
   input  wire logic [arr_pkg::CSR_W-1:0] csr_wdata
);

   logic [arr_pkg::IP_W-1:0]  local_ip_ff;
   logic [arr_pkg::MAC_W-1:0] local_mac_ff;
   arr_pkg::job_type          job;
   logic                      job_ready;
   logic                      accept;

   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= arr_pkg::LOCAL_IP_RESET;
         local_mac_ff <= arr_pkg::LOCAL_MAC_RESET;
      end else if (csr_wr_en) begin
         unique case (arr_pkg::csr_index_type'(csr_index))
            arr_pkg::CSR_LOCAL_IP:  local_ip_ff  <= csr_wdata[arr_pkg::IP_W-1:0];
            arr_pkg::CSR_LOCAL_MAC: local_mac_ff <= csr_wdata[arr_pkg::MAC_W-1:0];
            default: ;
         endcase
      end
   end

   arr_rx_parser u_rx (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .rx_last  (req_rx_last),
      .local_ip (local_ip_ff),
      .job      (job)
   );

   arr_tx_builder u_tx (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .job_ready   (job_ready),
      .local_mac   (local_mac_ff),
      .local_ip    (local_ip_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last)
   );

endmodule

`default_nettype wire

@@ bench/tb_arp_reply_responder.sv @@
`timescale 1ns / 100ps
// Testbench for arp_reply_responder: drives Ethernet frames byte by byte and checks
// every ARP reply byte against a predictor of the responder kept in this file.
// Depends on arr_pkg (CSR width and register indexes) and the RTL top level.

module tb_arp_reply_responder;

   localparam int ARP_LEN        = 42;
   localparam int OFS_TYPE       = 12;
   localparam int OFS_SHA        = 22;
   localparam int OFS_SPA        = 28;
   localparam int OFS_TPA        = 38;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_SETTLE     = 60;
   localparam int HOLD_CYCLES    = 600;
   localparam int RAND_PHASES    = 4;
   localparam int PHASE_FRAMES   = 45;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_REPORTS    = 40;

   localparam logic [31:0] IP_RST = 32'h0A42_1844;
   localparam logic [47:0] SHA_A  = 48'h0200_0000_0001;
   localparam logic [31:0] SPA_A  = 32'hC0A8_0001;

   typedef enum logic [1:0] {
      WANT_ANY,
      WANT_NONE,
      WANT_REPLY
   } reply_want_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } reply_beat_type;

   typedef struct {
      bit             set_cfg;
      logic [31:0]    cfg_ip;
      logic [47:0]    cfg_mac;
      int             len;
      logic [15:0]    etype;
      logic [47:0]    sha;
      logic [31:0]    spa;
      logic [31:0]    tpa;
      logic [15:0]    oper;
      bit             pad_random;
      logic [7:0]     pad;
      reply_want_type want;
   } arp_case_type;

   // frame cases: reset config first, then all-ones, all-zero and ordinary config settings
   arp_case_type directed_cases [0:17] = '{
      '{0, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_REPLY},
      '{0, 32'h0, 48'h0, 41, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 1, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 0, 8'hFF, WANT_NONE},
      '{0, 32'h0, 48'h0, 13, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 64, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_REPLY},
      '{0, 32'h0, 48'h0, 100, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 0, 8'hFF, WANT_REPLY},
      '{0, 32'h0, 48'h0, 42, 16'h0800, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 42, 16'h0807, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 42, 16'h0906, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, IP_RST + 32'd1,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0002, 1, 8'h00, WANT_REPLY},
      '{0, 32'h0, 48'h0, 42, 16'h0806, '1, '1, IP_RST,
        16'hFFFF, 0, 8'hFF, WANT_REPLY},
      '{0, 32'h0, 48'h0, 42, 16'h0806, '0, '0, IP_RST,
        16'h0000, 0, 8'h00, WANT_REPLY},
      '{1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 42, 16'h0806, SHA_A, SPA_A, 32'hFFFF_FFFF,
        16'h0001, 1, 8'h00, WANT_REPLY},
      '{0, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, 32'hFFFF_FFFE,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{0, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, IP_RST,
        16'h0001, 1, 8'h00, WANT_NONE},
      '{1, 32'h0, 48'h0, 42, 16'h0806, SHA_A, SPA_A, 32'h0,
        16'h0001, 0, 8'h00, WANT_REPLY},
      '{1, 32'hC0A8_0102, 48'h02AA_5501_807F, 42, 16'h0806, SHA_A, SPA_A, 32'hC0A8_0102,
        16'h0001, 1, 8'h00, WANT_REPLY}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      req_rx_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_tx_byte;
   logic                      rsp_tx_last;
   logic                      csr_wr_en = 1'b0;
   logic [0:0]                csr_index = arr_pkg::CSR_LOCAL_IP;
   logic [arr_pkg::CSR_W-1:0] csr_wdata = '0;

   // predictor state and configuration
   logic [5:0]  rx_pos        = '0;
   logic        rx_is_arp     = 1'b0;
   logic [47:0] cap_peer_mac  = '0;
   logic [31:0] cap_peer_ip   = '0;
   logic [31:0] cap_target_ip = '0;
   logic [31:0] cfg_local_ip  = IP_RST;
   logic [47:0] cfg_local_mac = '0;

   rx_item_type    rx_q [$];
   reply_want_type frame_want_q [$];
   reply_beat_type reply_q [$];

   int errors         = 0;
   int rx_pushed      = 0;
   int rx_accepted    = 0;
   int frames_queued  = 0;
   int replies_due    = 0;
   int replies_seen   = 0;
   int bytes_checked  = 0;
   int cfg_writes     = 0;
   int hold_asks      = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int gap_left       = 0;
   int burst_left     = 0;
   int mode_left      = 0;
   int cycle_count    = 0;
   logic [15:0] stall_pat = 16'hFFFF;

   arp_reply_responder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .req_rx_last (req_rx_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string what, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h actual %h", $time, what, exp_v, act_v);
   endtask

   // advance the responder predictor by one received byte
   task automatic arp_track_byte(input logic [7:0] b, input logic last);
      logic [5:0]     pos;
      logic [335:0]   reply;
      reply_want_type want;
      reply_beat_type beat;
      bit             answer;
      pos = rx_pos;
      if (pos == OFS_TYPE) rx_is_arp = (b == 8'h08);
      else if (pos == OFS_TYPE + 1) rx_is_arp = rx_is_arp && (b == 8'h06);
      else if (pos >= OFS_SHA && pos < OFS_SPA) cap_peer_mac = {cap_peer_mac[39:0], b};
      else if (pos >= OFS_SPA && pos < OFS_SPA + 4) cap_peer_ip = {cap_peer_ip[23:0], b};
      else if (pos >= OFS_TPA && pos < ARP_LEN) cap_target_ip = {cap_target_ip[23:0], b};
      if (pos < ARP_LEN) pos++;
      if (last) begin
         answer = (pos == ARP_LEN) && rx_is_arp && (cap_target_ip == cfg_local_ip);
         want = frame_want_q.pop_front();
         if (want != WANT_ANY && answer != (want == WANT_REPLY))
            flag_error("reply decision", 8'(want == WANT_REPLY), 8'(answer));
         if (answer) begin
            reply = {cap_peer_mac, cfg_local_mac, 16'h0806, 16'h0001, 16'h0800, 8'h06,
                     8'h04, 16'h0002, cfg_local_mac, cfg_local_ip, cap_peer_mac,
                     cap_peer_ip};
            for (int k = 0; k < ARP_LEN; k++) begin
               beat.tx_byte = reply[(ARP_LEN - 1 - k) * 8 +: 8];
               beat.tx_last = (k == ARP_LEN - 1);
               reply_q.push_back(beat);
            end
            replies_due++;
         end
         rx_pos = '0;
         rx_is_arp = 1'b0;
      end else begin
         rx_pos = pos;
      end
   endtask

   // sender: bursts of bytes with random gaps
   always @(posedge clock) begin
      rx_item_type item;
      logic        nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            arp_track_byte(req_rx_byte, req_rx_last);
            rx_accepted++;
         end
         if (!req_valid || req_ready) begin
            nxt_valid = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (rx_q.size() != 0) begin
               item = rx_q.pop_front();
               nxt_valid = 1'b1;
               req_rx_byte <= item.rx_byte;
               req_rx_last <= item.rx_last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
            req_valid <= nxt_valid;
         end
      end
   end

   // receiver: checks reply bytes, stalls on a rotating pattern or a long hold
   always @(posedge clock) begin
      reply_beat_type exp_beat;
      logic           nxt_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_q.size() == 0) begin
            flag_error("unexpected tx_byte", 8'h00, rsp_tx_byte);
         end else begin
            exp_beat = reply_q.pop_front();
            if (rsp_tx_byte !== exp_beat.tx_byte)
               flag_error("tx_byte", exp_beat.tx_byte, rsp_tx_byte);
            if (rsp_tx_last !== exp_beat.tx_last)
               flag_error("tx_last", 8'(exp_beat.tx_last), 8'(rsp_tx_last));
            bytes_checked++;
            if (exp_beat.tx_last) replies_seen++;
         end
      end
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         nxt_ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
         end else begin
            mode_left--;
         end
         stall_pat = {stall_pat[0], stall_pat[15:1]};
         nxt_ready = stall_pat[0];
      end
      rsp_ready <= nxt_ready;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("%0t: timeout, %0d reply bytes still due", $time, reply_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic wait_idle(input int settle);
      while (rx_accepted != rx_pushed || reply_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_local(input logic [31:0] ip, input logic [47:0] mac);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= arr_pkg::CSR_LOCAL_IP;
      csr_wdata <= arr_pkg::CSR_W'(ip);
      @(posedge clock);
      csr_index <= arr_pkg::CSR_LOCAL_MAC;
      csr_wdata <= arr_pkg::CSR_W'(mac);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_local_ip = ip;
      cfg_local_mac = mac;
      cfg_writes++;
   endtask

   task automatic queue_frame(input int len, input logic [15:0] etype,
                              input logic [47:0] sha, input logic [31:0] spa,
                              input logic [31:0] tpa, input logic [15:0] oper,
                              input bit pad_random, input logic [7:0] pad,
                              input reply_want_type want);
      rx_item_type item;
      logic [63:0] arp_hdr;
      logic [7:0]  b;
      arp_hdr = {16'h0001, 16'h0800, 8'h06, 8'h04, oper};
      frame_want_q.push_back(want);
      frames_queued++;
      for (int p = 0; p < len; p++) begin
         b = pad_random ? 8'($urandom) : pad;
         if (p == OFS_TYPE) b = etype[15:8];
         else if (p == OFS_TYPE + 1) b = etype[7:0];
         else if (p >= 14 && p < OFS_SHA) b = arp_hdr[(OFS_SHA - 1 - p) * 8 +: 8];
         else if (p >= OFS_SHA && p < OFS_SPA) b = sha[(OFS_SPA - 1 - p) * 8 +: 8];
         else if (p >= OFS_SPA && p < OFS_SPA + 4) b = spa[(OFS_SPA + 3 - p) * 8 +: 8];
         else if (p >= OFS_TPA && p < ARP_LEN) b = tpa[(ARP_LEN - 1 - p) * 8 +: 8];
         item.rx_byte = b;
         item.rx_last = (p == len - 1);
         rx_q.push_back(item);
         rx_pushed++;
      end
   endtask

   task automatic queue_random_frame();
      int          kind;
      int          len;
      logic [15:0] etype;
      logic [31:0] tpa;
      logic [15:0] oper;
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) < 7) ? ARP_LEN : $urandom_range(43, 90);
      if ($urandom_range(0, 29) == 0) len = 130;
      etype = 16'h0806;
      tpa = cfg_local_ip;
      case ($urandom_range(0, 3))
         0: oper = 16'h0002;
         1: oper = 16'($urandom);
         default: oper = 16'h0001;
      endcase
      if (kind >= 92) begin
         etype = 16'($urandom);
         tpa = $urandom;
         len = $urandom_range(1, 80);
      end else if (kind >= 82) begin
         len = $urandom_range(1, ARP_LEN - 1);
      end else if (kind >= 72) begin
         etype = etype ^ (16'd1 << $urandom_range(0, 15));
      end else if (kind >= 60) begin
         tpa = tpa ^ (32'd1 << $urandom_range(0, 31));
      end
      queue_frame(len, etype, 48'({$urandom, $urandom}), $urandom, tpa, oper, 1, 8'h00,
                  WANT_ANY);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         if (directed_cases[i].set_cfg) begin
            wait_idle(SETTLE_CYCLES);
            set_local(directed_cases[i].cfg_ip, directed_cases[i].cfg_mac);
         end
         queue_frame(directed_cases[i].len, directed_cases[i].etype, directed_cases[i].sha,
                     directed_cases[i].spa, directed_cases[i].tpa, directed_cases[i].oper,
                     directed_cases[i].pad_random, directed_cases[i].pad,
                     directed_cases[i].want);
      end

      // long receiver hold with back-to-back requests: reply path and pending slot fill
      wait_idle(SETTLE_CYCLES);
      hold_asks++;
      repeat (4)
         queue_frame(ARP_LEN, 16'h0806, 48'({$urandom, $urandom}), $urandom, cfg_local_ip,
                     16'h0001, 1, 8'h00, WANT_ANY);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle(SETTLE_CYCLES);
         set_local($urandom, 48'({$urandom, $urandom}));
         repeat (PHASE_FRAMES) queue_random_frame();
      end

      wait_idle(END_SETTLE);
      $display("summary: %0d frames (%0d bytes) over %0d address settings", frames_queued,
               rx_accepted, cfg_writes + 1);
      $display("summary: %0d of %0d ARP replies received, %0d reply bytes compared",
               replies_seen, replies_due, bytes_checked);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
